// ----- hw/rtl/min_coin_change_dp_top_defines.svh -----
// assertion macros for the minimum coin change block
`ifndef MIN_COIN_CHANGE_DP_TOP_DEFINES_SVH
`define MIN_COIN_CHANGE_DP_TOP_DEFINES_SVH

// same-cycle implication on clk, masked while in reset
`define MCC_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, masked while in reset
`define MCC_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mccdp_pkg.sv -----
// shared types, constants and helpers for the minimum coin change block
package mccdp_pkg;

  localparam int MAX_AMOUNT = 4096;
  localparam int MAX_COINS  = 6;
  localparam int COIN_REGS  = 6;

  localparam int COIN_W  = 12;
  localparam int TGT_W   = 12;
  localparam int CNT_W   = 12;
  localparam int ENT_W   = CNT_W + 1;
  localparam int CCNT_W  = 3;
  localparam int CFG_W   = 12;
  localparam int AMT_W   = $clog2(MAX_AMOUNT);
  localparam int CMP_W   = ((AMT_W > COIN_W) ? AMT_W : COIN_W) + 1;
  localparam int CIDX_W  = $clog2(COIN_REGS);
  localparam int NC_W    = $clog2(COIN_REGS + 1);
  localparam int CFG_IDX_W = $clog2(COIN_REGS + 1);
  localparam int USE_LIM = (MAX_COINS < COIN_REGS) ? MAX_COINS : COIN_REGS;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [ENT_W-1:0] ENT_UNREACH = {1'b1, {CNT_W{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_COIN_COUNT = CFG_IDX_W'(COIN_REGS);

  localparam logic [COIN_W-1:0] COIN_RESET [COIN_REGS] = '{
    12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd1
  };
  localparam logic [CCNT_W-1:0] COIN_COUNT_RESET = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic flush;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic tgt_zero;
    logic tgt_oor;
    logic last_coin;
    logic last_amt;
    logic out_free;
  } dp_sts_t;

  function automatic logic [NC_W-1:0] usable_coins(input logic [CCNT_W-1:0] cnt);
    logic [NC_W-1:0] k;
    if (int'(cnt) > USE_LIM) begin
      k = NC_W'(USE_LIM);
    end else begin
      k = NC_W'(cnt);
    end
    return k;
  endfunction

endpackage

// ----- hw/rtl/mccdp_ram.sv -----
// generic single-write single-read ram with registered read data
module mccdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/mccdp_ctrl.sv -----
// sequencing state machine for the coin change table rebuild
module mccdp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mccdp_pkg::dp_sts_t sts,
  output mccdp_pkg::dp_cmd_t cmd
);

  mccdp_pkg::state_t state_r;
  mccdp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mccdp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      mccdp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (sts.tgt_oor || sts.tgt_zero) begin
            state_nxt = mccdp_pkg::S_DONE;
          end else begin
            state_nxt = mccdp_pkg::S_SCAN;
          end
        end
      end
      mccdp_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_coin) begin
          state_nxt = mccdp_pkg::S_FLUSH;
        end
      end
      mccdp_pkg::S_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.last_amt) begin
          state_nxt = mccdp_pkg::S_DONE;
        end else begin
          state_nxt = mccdp_pkg::S_SCAN;
        end
      end
      mccdp_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = mccdp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mccdp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mccdp_dp.sv -----
// datapath: coin registers, amount and coin counters, table memory, result register
`include "min_coin_change_dp_top_defines.svh"

module mccdp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mccdp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mccdp_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [mccdp_pkg::TGT_W-1:0]          in_target_amount,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mccdp_pkg::CNT_W-1:0]          out_min_coins,
  output logic                                 out_unreachable,
  input  mccdp_pkg::dp_cmd_t                   cmd,
  output mccdp_pkg::dp_sts_t                   sts
);

  logic [mccdp_pkg::COIN_W-1:0] coin_r [mccdp_pkg::COIN_REGS];
  logic [mccdp_pkg::CCNT_W-1:0] coin_count_r;

  logic [mccdp_pkg::TGT_W-1:0]  target_r;
  logic [mccdp_pkg::AMT_W-1:0]  amt_r;
  logic [mccdp_pkg::CIDX_W-1:0] coin_idx_r;
  logic                         pend_r;
  logic [mccdp_pkg::ENT_W-1:0]  best_r;
  logic [mccdp_pkg::ENT_W-1:0]  res_r;
  logic                         out_valid_r;
  logic [mccdp_pkg::CNT_W-1:0]  out_min_coins_r;
  logic                         out_unreachable_r;

  logic [mccdp_pkg::NC_W-1:0]   ncoins;
  logic [mccdp_pkg::COIN_W-1:0] coin_val;
  logic [mccdp_pkg::CMP_W-1:0]  amt_cmp;
  logic [mccdp_pkg::CMP_W-1:0]  coin_cmp;
  logic [mccdp_pkg::CMP_W-1:0]  tgt_cmp;
  logic                         idx_ok;
  logic                         usable;
  logic [mccdp_pkg::AMT_W-1:0]  raddr;
  logic [mccdp_pkg::ENT_W-1:0]  rdata;
  logic [mccdp_pkg::CNT_W-1:0]  cand;
  logic                         take;
  logic [mccdp_pkg::ENT_W-1:0]  best_nxt;
  logic                         ram_we;
  logic [mccdp_pkg::AMT_W-1:0]  ram_waddr;
  logic [mccdp_pkg::ENT_W-1:0]  ram_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mccdp_pkg::COIN_REGS; i++) begin
        coin_r[i] <= mccdp_pkg::COIN_RESET[i];
      end
      coin_count_r <= mccdp_pkg::COIN_COUNT_RESET;
    end else if (cfg_we) begin
      for (int i = 0; i < mccdp_pkg::COIN_REGS; i++) begin
        if (cfg_index == mccdp_pkg::CFG_IDX_W'(i)) begin
          coin_r[i] <= cfg_wdata[mccdp_pkg::COIN_W-1:0];
        end
      end
      if (cfg_index == mccdp_pkg::CFG_COIN_COUNT) begin
        coin_count_r <= cfg_wdata[mccdp_pkg::CCNT_W-1:0];
      end
    end
  end

  assign ncoins   = mccdp_pkg::usable_coins(coin_count_r);
  assign idx_ok   = mccdp_pkg::NC_W'(coin_idx_r) < ncoins;
  assign coin_val = idx_ok ? coin_r[coin_idx_r] : '0;
  assign amt_cmp  = mccdp_pkg::CMP_W'(amt_r);
  assign coin_cmp = mccdp_pkg::CMP_W'(coin_val);
  assign tgt_cmp  = mccdp_pkg::CMP_W'(target_r);
  assign usable   = idx_ok && (coin_val != '0) && (coin_cmp <= amt_cmp);
  assign raddr    = mccdp_pkg::AMT_W'(amt_cmp - coin_cmp);

  // candidate from the entry read last cycle
  assign cand = (rdata[mccdp_pkg::CNT_W-1:0] == mccdp_pkg::CNT_MAX) ?
                mccdp_pkg::CNT_MAX : rdata[mccdp_pkg::CNT_W-1:0] + 1'b1;
  assign take = pend_r && !rdata[mccdp_pkg::ENT_W-1] &&
                (best_r[mccdp_pkg::ENT_W-1] || (cand < best_r[mccdp_pkg::CNT_W-1:0]));
  assign best_nxt = take ? {1'b0, cand} : best_r;

  assign ram_we    = cmd.start || cmd.flush;
  assign ram_waddr = cmd.start ? '0 : amt_r;
  assign ram_wdata = cmd.start ? '0 : best_nxt;

  mccdp_ram #(
    .WIDTH (mccdp_pkg::ENT_W),
    .DEPTH (mccdp_pkg::MAX_AMOUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // table rebuild registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      coin_idx_r <= '0;
      amt_r      <= '0;
    end else if (cmd.start) begin
      pend_r     <= 1'b0;
      coin_idx_r <= '0;
      amt_r      <= mccdp_pkg::AMT_W'(1);
    end else if (cmd.scan) begin
      pend_r <= usable;
      if (!sts.last_coin) begin
        coin_idx_r <= coin_idx_r + 1'b1;
      end
    end else if (cmd.flush) begin
      pend_r     <= 1'b0;
      coin_idx_r <= '0;
      amt_r      <= amt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target_r <= in_target_amount;
      best_r   <= mccdp_pkg::ENT_UNREACH;
      res_r    <= sts.tgt_oor ? mccdp_pkg::ENT_UNREACH : '0;
    end else if (cmd.scan) begin
      best_r <= best_nxt;
    end else if (cmd.flush) begin
      best_r <= mccdp_pkg::ENT_UNREACH;
      res_r  <= best_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_unreachable_r <= res_r[mccdp_pkg::ENT_W-1];
      out_min_coins_r   <= res_r[mccdp_pkg::ENT_W-1] ? '0 : res_r[mccdp_pkg::CNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_min_coins   = out_min_coins_r;
  assign out_unreachable = out_unreachable_r;

  assign sts.tgt_zero  = in_target_amount == '0;
  assign sts.tgt_oor   = 32'(in_target_amount) >= 32'(mccdp_pkg::MAX_AMOUNT);
  assign sts.last_coin = (ncoins == '0) ||
                         (mccdp_pkg::NC_W'(coin_idx_r) == ncoins - 1'b1);
  assign sts.last_amt  = amt_cmp == tgt_cmp;
  assign sts.out_free  = !out_valid_r || !out_stall;

  `MCC_CHK_NOW(a_no_clobber, cmd.load_out, !(out_valid_r && out_stall),
               "result register overwritten before transfer")
  `MCC_CHK_NOW(a_amt_range, cmd.scan || cmd.flush,
               (amt_r != '0) && (amt_cmp <= tgt_cmp), "amount outside 1..target")
  `MCC_CHK_NOW(a_pend_src, pend_r, $past(cmd.scan), "pending read without scan")
  `MCC_CHK_NEXT(a_res_nonzero, cmd.flush,
                res_r[mccdp_pkg::ENT_W-1] || (res_r[mccdp_pkg::CNT_W-1:0] != '0),
                "reachable nonzero amount with zero coins")

endmodule

// ----- hw/rtl/min_coin_change_dp_top.sv -----
// flow: one item at a time, k reads of the table memory per amount plus one write,
//   k = usable coin count; a zero target skips the table rebuild
//   while a result is stalled, the next result waits in the block
// reset: synchronous active-low, coins return to 1,2,3,4,5,1 with count 5; the table
//   memory is not cleared, every item rewrites entries 0..target before reading them
module min_coin_change_dp_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mccdp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mccdp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mccdp_pkg::TGT_W-1:0]     in_target_amount,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mccdp_pkg::CNT_W-1:0]     out_min_coins,
  output logic                            out_unreachable
);

  mccdp_pkg::dp_cmd_t cmd;
  mccdp_pkg::dp_sts_t sts;

  mccdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mccdp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_target_amount (in_target_amount),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_min_coins    (out_min_coins),
    .out_unreachable  (out_unreachable),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ----- tb/min_coin_change_dp_top_tb.sv -----
// testbench for min_coin_change_dp_top: queued targets, fewest-coins predictor, result checks
`timescale 1ns / 1ps

module min_coin_change_dp_top_tb;

  localparam int CLK_HALF = 10;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam logic [mccdp_pkg::CFG_IDX_W-1:0] REG_SPARE =
    mccdp_pkg::CFG_IDX_W'(mccdp_pkg::COIN_REGS + 1);

  typedef struct packed {
    logic [mccdp_pkg::CNT_W-1:0] coins;
    logic                        unreach;
  } change_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [mccdp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mccdp_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [mccdp_pkg::TGT_W-1:0]     in_target_amount = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [mccdp_pkg::CNT_W-1:0]     out_min_coins;
  logic                            out_unreachable;

  logic [mccdp_pkg::COIN_W-1:0] coin_val [mccdp_pkg::COIN_REGS];
  logic [mccdp_pkg::CCNT_W-1:0] coin_cnt;
  logic [mccdp_pkg::ENT_W-1:0]  best_tbl [mccdp_pkg::MAX_AMOUNT];

  logic [mccdp_pkg::TGT_W-1:0] target_q [$];
  change_t                     due_change_q [$];
  change_t                     got;
  logic                        in_xfer = 1'b0;
  int                          burst_left = 0;
  int                          gap_left = 0;
  int                          stall_left = 0;
  int                          queued_cnt = 0;
  int                          out_cnt = 0;
  int                          fail_cnt = 0;
  int                          cycle_cnt = 0;

  min_coin_change_dp_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_target_amount (in_target_amount),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_min_coins    (out_min_coins),
    .out_unreachable  (out_unreachable)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic change_t fewest_coins(input logic [mccdp_pkg::TGT_W-1:0] target);
    logic [mccdp_pkg::ENT_W-1:0] best;
    logic [mccdp_pkg::CNT_W-1:0] cand;
    logic [mccdp_pkg::ENT_W-1:0] prev;
    int                          ncoins;
    change_t                     res;
    ncoins = (int'(coin_cnt) > mccdp_pkg::USE_LIM) ? mccdp_pkg::USE_LIM : int'(coin_cnt);
    best_tbl[0] = '0;
    for (int a = 1; a <= int'(target); a++) begin
      best = mccdp_pkg::ENT_UNREACH;
      for (int c = 0; c < ncoins; c++) begin
        if (coin_val[c] != '0 && int'(coin_val[c]) <= a) begin
          prev = best_tbl[a - int'(coin_val[c])];
          if (!prev[mccdp_pkg::CNT_W]) begin
            cand = prev[mccdp_pkg::CNT_W-1:0];
            if (cand != mccdp_pkg::CNT_MAX) cand = cand + 1'b1;
            if (best[mccdp_pkg::CNT_W] || cand < best[mccdp_pkg::CNT_W-1:0]) begin
              best = {1'b0, cand};
            end
          end
        end
      end
      best_tbl[a] = best;
    end
    if (best_tbl[target][mccdp_pkg::CNT_W]) begin
      res.coins = '0;
      res.unreach = 1'b1;
    end else begin
      res.coins = best_tbl[target][mccdp_pkg::CNT_W-1:0];
      res.unreach = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [mccdp_pkg::TGT_W-1:0] pick_target();
    logic [mccdp_pkg::TGT_W-1:0] t;
    case ($urandom_range(0, 19))
      0: t = mccdp_pkg::TGT_W'($urandom_range(3000, mccdp_pkg::MAX_AMOUNT - 1));
      1: t = mccdp_pkg::TGT_W'($urandom);
      default: t = mccdp_pkg::TGT_W'($urandom_range(0, 250));
    endcase
    return t;
  endfunction

  function automatic logic [mccdp_pkg::COIN_W-1:0] pick_coin();
    logic [mccdp_pkg::COIN_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = mccdp_pkg::COIN_W'($urandom_range(1, 4095));
      default: v = mccdp_pkg::COIN_W'($urandom_range(1, 40));
    endcase
    return v;
  endfunction

  // register writes happen only while the block is idle
  task automatic set_reg(input logic [mccdp_pkg::CFG_IDX_W-1:0] idx,
                         input logic [mccdp_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (int'(idx) < mccdp_pkg::COIN_REGS) begin
      coin_val[idx] = data[mccdp_pkg::COIN_W-1:0];
    end else if (idx == mccdp_pkg::CFG_COIN_COUNT) begin
      coin_cnt = data[mccdp_pkg::CCNT_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_target(input logic [mccdp_pkg::TGT_W-1:0] t);
    target_q.push_back(t);
    queued_cnt++;
  endtask

  task automatic settle();
    while (out_cnt < queued_cnt) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_targets(input int n);
    @(posedge clk);
    for (int i = 0; i < n; i++) queue_target(pick_target());
    settle();
  endtask

  // input driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_xfer) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (target_q.size() != 0) begin
        in_valid <= 1'b1;
        in_target_amount <= target_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall pattern with long stall-free stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(50, 400);
        end
        1, 2: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(0, 12);
        end
        default: begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(0, 6);
        end
      endcase
    end
  end

  // input capture, result checking and timeout
  always @(posedge clk) begin
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      cycle_cnt++;
      in_xfer <= in_valid && !in_stall;
      if (in_valid && !in_stall) due_change_q.push_back(fewest_coins(in_target_amount));
      if (out_valid && !out_stall) begin
        out_cnt++;
        if (due_change_q.size() == 0) begin
          $error("unexpected result transfer: min_coins=%0d unreachable=%0b",
                 out_min_coins, out_unreachable);
          fail_cnt++;
        end else begin
          got = due_change_q.pop_front();
          if (out_min_coins !== got.coins) begin
            $error("min_coins: expected %0d, actual %0d", got.coins, out_min_coins);
            fail_cnt++;
          end
          if (out_unreachable !== got.unreach) begin
            $error("unreachable: expected %0b, actual %0b", got.unreach, out_unreachable);
            fail_cnt++;
          end
        end
      end
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < mccdp_pkg::COIN_REGS; i++) coin_val[i] = mccdp_pkg::COIN_RESET[i];
    coin_cnt = mccdp_pkg::COIN_COUNT_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset coins 1,2,3,4,5 in use
    @(posedge clk);
    queue_target(12'd0);
    queue_target(12'd1);
    queue_target(12'd2);
    queue_target(12'd4095);
    queue_target(12'hAAA);
    queue_target(12'h555);
    queue_target(12'd9);
    settle();
    random_targets(16);

    // unused index, a zero coin and an oversized count
    set_reg(REG_SPARE, 12'd9);
    set_reg(mccdp_pkg::CFG_IDX_W'(0), 12'd4095);
    set_reg(mccdp_pkg::CFG_IDX_W'(1), 12'd2048);
    set_reg(mccdp_pkg::CFG_IDX_W'(2), 12'd0);
    set_reg(mccdp_pkg::CFG_IDX_W'(3), 12'd7);
    set_reg(mccdp_pkg::CFG_IDX_W'(4), 12'd5);
    set_reg(mccdp_pkg::CFG_IDX_W'(5), 12'd3);
    set_reg(mccdp_pkg::CFG_COIN_COUNT, 12'hFF7);
    @(posedge clk);
    queue_target(12'd4095);
    queue_target(12'd2048);
    queue_target(12'd1);
    queue_target(12'd10);
    queue_target(12'd4094);
    settle();
    random_targets(16);

    // no coin usable
    set_reg(mccdp_pkg::CFG_COIN_COUNT, 12'd0);
    @(posedge clk);
    queue_target(12'd0);
    queue_target(12'd1);
    queue_target(12'd300);
    settle();

    // single unit coin, largest count
    set_reg(mccdp_pkg::CFG_IDX_W'(0), 12'd1);
    set_reg(mccdp_pkg::CFG_COIN_COUNT, 12'd1);
    @(posedge clk);
    queue_target(12'd4095);
    queue_target(12'd100);
    settle();

    // single coin of three
    set_reg(mccdp_pkg::CFG_IDX_W'(0), 12'd3);
    @(posedge clk);
    queue_target(12'd9);
    queue_target(12'd10);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < mccdp_pkg::COIN_REGS; i++) begin
        set_reg(mccdp_pkg::CFG_IDX_W'(i), pick_coin());
      end
      set_reg(mccdp_pkg::CFG_COIN_COUNT, mccdp_pkg::CFG_W'($urandom_range(0, 7)));
      random_targets(10);
    end

    settle();
    repeat (20) @(negedge clk);
    if (due_change_q.size() != 0) begin
      $error("%0d expected results never arrived", due_change_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mccdp_pkg.sv
hw/rtl/mccdp_ram.sv
hw/rtl/mccdp_ctrl.sv
hw/rtl/mccdp_dp.sv
hw/rtl/min_coin_change_dp_top.sv
tb/min_coin_change_dp_top_tb.sv
